// ===== hw/rtl/owm_pkg.sv =====
package owm_pkg;

    localparam int TIMER_BITS = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_NUM    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CMP_W      = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_W-1:0]      cfg_t;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_SMPL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SMPL     = 3'd5;

    localparam cfg_t RESET_LOW_DEFAULT     = 10'd500;
    localparam cfg_t PRESENCE_SMPL_DEFAULT = 10'd60;
    localparam cfg_t SLOT_LOW_DEFAULT      = 10'd2;
    localparam cfg_t SLOT_DEFAULT          = 10'd60;
    localparam cfg_t RECOVERY_DEFAULT      = 10'd1;
    localparam cfg_t READ_SMPL_DEFAULT     = 10'd2;

    localparam logic [7:0] ROM_SKIP_CMD   = 8'hCC;
    localparam logic [7:0] CONVERT_CMD    = 8'h44;
    localparam logic [7:0] READ_SCRATCH   = 8'hBE;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_SAMPLE,
        PH_W_LOW,
        PH_W_SLOT,
        PH_W_RECOV,
        PH_R_LOW,
        PH_R_DELAY,
        PH_R_REST
    } phase_t;

    typedef enum logic [1:0] {
        OP_RESET,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        KIND_RESET,
        KIND_WRITE,
        KIND_READ,
        KIND_CONVERT,
        KIND_TEMP
    } kind_t;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [7:0]        read_byte;
        logic signed [15:0] temperature_raw;
    } result_t;

    function automatic logic [2:0] seq_len(input logic [2:0] kind);
        logic [2:0] len;
        case (kind)
            KIND_CONVERT: len = 3'd3;
            KIND_TEMP:    len = 3'd4;
            default:      len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic op_t seq_op(input logic [2:0] kind, input logic [1:0] step);
        op_t op;
        case (kind)
            KIND_WRITE:   op = OP_WRITE;
            KIND_READ:    op = OP_READ;
            KIND_CONVERT: op = (step == 2'd0) ? OP_RESET : OP_WRITE;
            KIND_TEMP:    op = (step[1]) ? OP_READ : OP_WRITE;
            default:      op = OP_RESET;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [1:0] step);
        logic [7:0] b;
        b = 8'h00;
        if (kind == KIND_CONVERT) begin
            if (step == 2'd1) begin
                b = ROM_SKIP_CMD;
            end else if (step == 2'd2) begin
                b = CONVERT_CMD;
            end
        end else if (kind == KIND_TEMP) begin
            if (step == 2'd0) begin
                b = ROM_SKIP_CMD;
            end else if (step == 2'd1) begin
                b = READ_SCRATCH;
            end
        end
        return b;
    endfunction

    function automatic logic tick_elapsed(input timer_t t, input cfg_t n);
        return ((CMP_W'(t) + CMP_W'(1)) >= CMP_W'(n)) || (t == '1);
    endfunction

    function automatic phase_t op_phase(input op_t op);
        phase_t ph;
        case (op)
            OP_RESET: ph = PH_RST_LOW;
            OP_WRITE: ph = PH_W_LOW;
            default:  ph = PH_R_LOW;
        endcase
        return ph;
    endfunction

endpackage

// ===== hw/rtl/owm_core.sv =====
module owm_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic                                line_level,
    input  logic                                start_req,
    input  logic [2:0]                          kind,
    input  logic [7:0]                          write_byte,
    input  logic                                cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  owm_pkg::cfg_t                       cfg_data,
    output owm_pkg::result_t                    result
);

    owm_pkg::cfg_t   cfg_reg [owm_pkg::CFG_NUM];

    owm_pkg::phase_t phase_reg, phase_next;
    owm_pkg::timer_t timer_reg, timer_next;
    logic [2:0]      bit_idx_reg, bit_idx_next;
    logic [7:0]      shift_reg, shift_next;
    logic [2:0]      step_reg, step_next;
    logic [2:0]      akind_reg, akind_next;
    logic [7:0]      low_held_reg, low_held_next;
    logic            pres_reg, pres_next;
    logic [7:0]      rbyte_reg, rbyte_next;
    logic [15:0]     rword_reg, rword_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[owm_pkg::CFG_RESET_LOW]     <= owm_pkg::RESET_LOW_DEFAULT;
            cfg_reg[owm_pkg::CFG_PRESENCE_SMPL] <= owm_pkg::PRESENCE_SMPL_DEFAULT;
            cfg_reg[owm_pkg::CFG_SLOT_LOW]      <= owm_pkg::SLOT_LOW_DEFAULT;
            cfg_reg[owm_pkg::CFG_SLOT]          <= owm_pkg::SLOT_DEFAULT;
            cfg_reg[owm_pkg::CFG_RECOVERY]      <= owm_pkg::RECOVERY_DEFAULT;
            cfg_reg[owm_pkg::CFG_READ_SMPL]     <= owm_pkg::READ_SMPL_DEFAULT;
        end else if (cfg_we && (cfg_index < owm_pkg::CFG_IDX_W'(owm_pkg::CFG_NUM))) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= owm_pkg::PH_IDLE;
            timer_reg    <= '0;
            bit_idx_reg  <= '0;
            shift_reg    <= '0;
            step_reg     <= '0;
            akind_reg    <= '0;
            low_held_reg <= '0;
            pres_reg     <= 1'b0;
            rbyte_reg    <= '0;
            rword_reg    <= '0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            step_reg     <= step_next;
            akind_reg    <= akind_next;
            low_held_reg <= low_held_next;
            pres_reg     <= pres_next;
            rbyte_reg    <= rbyte_next;
            rword_reg    <= rword_next;
        end
    end

    // One bus tick: optional command start, then the current phase, then the
    // end of an operation, which may chain into the next operation of the command.
    always_comb begin
        logic          drive;
        logic          done;
        logic          el;
        logic          end_op;
        logic [1:0]    s;
        owm_pkg::op_t  op;

        phase_next    = phase_reg;
        timer_next    = timer_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        step_next     = step_reg;
        akind_next    = akind_reg;
        low_held_next = low_held_reg;
        pres_next     = pres_reg;
        rbyte_next    = rbyte_reg;
        rword_next    = rword_reg;
        drive         = 1'b0;
        done          = 1'b0;
        el            = 1'b0;
        end_op        = 1'b0;
        s             = 2'd0;
        op            = owm_pkg::OP_RESET;

        if ((phase_reg == owm_pkg::PH_IDLE) && start_req && (kind <= owm_pkg::KIND_TEMP)) begin
            akind_next   = kind;
            step_next    = 3'd0;
            timer_next   = '0;
            bit_idx_next = 3'd0;
            shift_next   = (kind == owm_pkg::KIND_WRITE) ? write_byte
                                                         : owm_pkg::seq_byte(kind, 2'd0);
            phase_next   = owm_pkg::op_phase(owm_pkg::seq_op(kind, 2'd0));
        end

        unique case (phase_next)
            owm_pkg::PH_RST_LOW: begin
                drive = 1'b1;
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_RESET_LOW]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    phase_next = owm_pkg::PH_RST_WAIT;
                end
            end
            owm_pkg::PH_RST_WAIT: begin
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_PRESENCE_SMPL]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    phase_next = owm_pkg::PH_RST_SAMPLE;
                end
            end
            owm_pkg::PH_RST_SAMPLE: begin
                if (timer_next == '0) begin
                    pres_next  = ~line_level;
                    timer_next = owm_pkg::timer_t'(1);
                end
                end_op = line_level;
            end
            owm_pkg::PH_W_LOW: begin
                drive = 1'b1;
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_SLOT_LOW]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    phase_next = owm_pkg::PH_W_SLOT;
                end
            end
            owm_pkg::PH_W_SLOT: begin
                drive = ~shift_next[bit_idx_next];
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_SLOT]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    phase_next = owm_pkg::PH_W_RECOV;
                end
            end
            owm_pkg::PH_W_RECOV: begin
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_RECOVERY]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    if (bit_idx_next == 3'd7) begin
                        end_op = 1'b1;
                    end else begin
                        bit_idx_next = bit_idx_next + 3'd1;
                        phase_next   = owm_pkg::PH_W_LOW;
                    end
                end
            end
            owm_pkg::PH_R_LOW: begin
                drive = 1'b1;
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_SLOT_LOW]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    phase_next = owm_pkg::PH_R_DELAY;
                end
            end
            owm_pkg::PH_R_DELAY: begin
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_READ_SMPL]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    phase_next = owm_pkg::PH_R_REST;
                end
            end
            owm_pkg::PH_R_REST: begin
                if (timer_next == '0) begin
                    shift_next[bit_idx_next] = shift_next[bit_idx_next] | line_level;
                end
                el = owm_pkg::tick_elapsed(timer_next, cfg_reg[owm_pkg::CFG_SLOT]);
                timer_next = el ? '0 : timer_next + 1'b1;
                if (el) begin
                    if (bit_idx_next == 3'd7) begin
                        end_op = 1'b1;
                    end else begin
                        bit_idx_next = bit_idx_next + 3'd1;
                        phase_next   = owm_pkg::PH_R_LOW;
                    end
                end
            end
            default: begin
                phase_next = owm_pkg::PH_IDLE;
            end
        endcase

        if (end_op) begin
            s = step_next[1:0];
            if (owm_pkg::seq_op(akind_next, s) == owm_pkg::OP_READ) begin
                rbyte_next = shift_next;
                if ((akind_next == owm_pkg::KIND_TEMP) && (s == 2'd2)) begin
                    low_held_next = shift_next;
                end
                if ((akind_next == owm_pkg::KIND_TEMP) && (s == 2'd3)) begin
                    rword_next = {shift_next, low_held_next};
                end
            end
            step_next = step_next + 3'd1;
            if (((akind_next == owm_pkg::KIND_CONVERT) && (step_next == 3'd1) && !pres_next) ||
                (step_next >= owm_pkg::seq_len(akind_next))) begin
                phase_next = owm_pkg::PH_IDLE;
                timer_next = '0;
                done       = 1'b1;
            end else begin
                op           = owm_pkg::seq_op(akind_next, step_next[1:0]);
                timer_next   = '0;
                bit_idx_next = 3'd0;
                shift_next   = owm_pkg::seq_byte(akind_next, step_next[1:0]);
                phase_next   = owm_pkg::op_phase(op);
            end
        end

        result.drive_low       = drive;
        result.busy_res        = (phase_next != owm_pkg::PH_IDLE);
        result.done_res        = done;
        result.presence        = pres_next;
        result.read_byte       = rbyte_next;
        result.temperature_raw = rword_next;
    end

endmodule

// ===== hw/rtl/one_wire_bus_master_unit.sv =====
// Path: an accepted beat is captured in the input stage, then its result is
// written to the result register once the result side is not stalled.
// Throughput: one beat per clock cycle unless m_ready stalls the output, set by
// the single input stage and result register around the per-tick phase logic.
// Reset: synchronous, active low; both channels empty, phase idle, core status
// cleared, timing registers at their defaults; the result register is not reset.
module one_wire_bus_master_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_line_level,
    input  logic                            s_start_req,
    input  logic [2:0]                      s_kind,
    input  logic [7:0]                      s_write_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_drive_low,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic                            m_presence,
    output logic [7:0]                      m_read_byte,
    output logic signed [15:0]              m_temperature_raw,
    input  logic                            cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owm_pkg::CFG_W-1:0]       cfg_data
);

    logic             in_valid_reg;
    logic             in_line_reg;
    logic             in_start_reg;
    logic [2:0]       in_kind_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    owm_pkg::result_t out_reg;
    owm_pkg::result_t step_result;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_line_reg  <= s_line_level;
            in_start_reg <= s_start_req;
            in_kind_reg  <= s_kind;
            in_byte_reg  <= s_write_byte;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    owm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .line_level (in_line_reg),
        .start_req  (in_start_reg),
        .kind       (in_kind_reg),
        .write_byte (in_byte_reg),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (step_result)
    );

    assign m_valid           = out_valid_reg;
    assign m_drive_low       = out_reg.drive_low;
    assign m_busy_res        = out_reg.busy_res;
    assign m_done_res        = out_reg.done_res;
    assign m_presence        = out_reg.presence;
    assign m_read_byte       = out_reg.read_byte;
    assign m_temperature_raw = out_reg.temperature_raw;

endmodule
